// ===== hw/rtl/css_pkg.sv =====
package css_pkg;

   typedef struct packed {
      logic [8:0]         sensor_normal_mask;
      logic               flow_normal;
      logic signed [15:0] return_temp;
      logic signed [15:0] target_temp;
      logic               compressor_on;
      logic               geo_pump_ready;
      logic               loop1_pump_ready;
      logic               loop2_pump_ready;
      logic [31:0]        seconds_now;
   } css_req_type;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] pump_start_mask;
      logic [2:0] pump_stop_mask;
      logic       compressor_start;
      logic       compressor_stop;
      logic       sequence_result;
   } css_rsp_type;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   localparam logic [8:0] SENSOR_ALL = 9'h1FF;

   localparam logic [2:0] PUMP_GEO   = 3'b001;
   localparam logic [2:0] PUMP_LOOP1 = 3'b010;
   localparam logic [2:0] PUMP_LOOP2 = 3'b100;

   localparam logic [0:0] CSR_START_DELAY = 1'b0;
   localparam logic [0:0] CSR_STOP_DELAY  = 1'b1;

   localparam int unsigned DELAY_WIDTH = 16;
   localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 16'd30;

endpackage

// ===== hw/rtl/css_step.sv =====
module css_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  css_pkg::css_req_type req,
   input  logic [15:0]         start_delay,
   input  logic [15:0]         stop_delay,
   output css_pkg::css_rsp_type rsp
);
   import css_pkg::*;

   localparam logic [2:0] PH0 = 3'd0;
   localparam logic [2:0] PH1 = 3'd1;
   localparam logic [2:0] PH2 = 3'd2;
   localparam logic [2:0] PH3 = 3'd3;
   localparam logic [2:0] PH4 = 3'd4;

   logic [2:0]  start_phase_ff, start_phase_in;
   logic [2:0]  stop_phase_ff, stop_phase_in;
   logic [31:0] start_stamp_ff, start_stamp_in;
   logic [31:0] stop_stamp_ff, stop_stamp_in;

   always_comb begin
      logic        run_ok;
      logic [1:0]  cmd;
      logic [2:0]  sp;
      logic [2:0]  tp;
      logic [31:0] sst;
      logic [31:0] tst;
      logic [31:0] elapsed;
      run_ok = (req.return_temp < req.target_temp) &&
               (req.sensor_normal_mask == SENSOR_ALL) && req.flow_normal;
      if (run_ok) begin
         cmd = req.compressor_on ? CMD_NONE : CMD_START;
      end else begin
         cmd = req.compressor_on ? CMD_STOP : CMD_NONE;
      end
      sp  = start_phase_ff;
      tp  = stop_phase_ff;
      sst = start_stamp_ff;
      tst = stop_stamp_ff;
      rsp = '0;
      rsp.command = cmd;
      elapsed = '0;
      if (cmd == CMD_START) begin
         if (sp == PH0) begin
            rsp.pump_start_mask = rsp.pump_start_mask | PUMP_GEO;
            rsp.sequence_result = req.geo_pump_ready;
            if (req.geo_pump_ready) sp = PH1;
         end
         if (sp == PH1) begin
            rsp.pump_start_mask = rsp.pump_start_mask | PUMP_LOOP1;
            rsp.sequence_result = req.loop1_pump_ready;
            if (req.loop1_pump_ready) sp = PH2;
         end
         if (sp == PH2) begin
            rsp.pump_start_mask = rsp.pump_start_mask | PUMP_LOOP2;
            rsp.sequence_result = req.loop2_pump_ready;
            if (req.loop2_pump_ready) begin
               sst = req.seconds_now;
               sp  = PH3;
            end
         end
         elapsed = req.seconds_now - sst;
         if (sp == PH3) begin
            if (elapsed >= {16'd0, start_delay}) sp = PH4;
         end
         if (sp == PH4) begin
            rsp.compressor_start = 1'b1;
            rsp.sequence_result  = 1'b1;
            sp = PH0;
         end
      end else if (cmd == CMD_STOP) begin
         if (tp == PH0) begin
            rsp.compressor_stop = 1'b1;
            rsp.sequence_result = 1'b1;
            tp  = PH1;
            tst = req.seconds_now;
         end
         elapsed = req.seconds_now - tst;
         if (tp == PH1) begin
            if (elapsed >= {16'd0, stop_delay}) tp = PH2;
         end
         if (tp == PH2) begin
            rsp.pump_stop_mask  = rsp.pump_stop_mask | PUMP_LOOP2;
            rsp.sequence_result = req.loop2_pump_ready;
            if (req.loop2_pump_ready) tp = PH3;
         end
         if (tp == PH3) begin
            rsp.pump_stop_mask  = rsp.pump_stop_mask | PUMP_LOOP1;
            rsp.sequence_result = req.loop1_pump_ready;
            if (req.loop1_pump_ready) tp = PH4;
         end
         if (tp == PH4) begin
            rsp.pump_stop_mask  = rsp.pump_stop_mask | PUMP_GEO;
            rsp.sequence_result = req.geo_pump_ready;
            tp = PH0;
         end
      end
      start_phase_in = sp;
      stop_phase_in  = tp;
      start_stamp_in = sst;
      stop_stamp_in  = tst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_phase_ff <= PH0;
         stop_phase_ff  <= PH0;
         start_stamp_ff <= '0;
         stop_stamp_ff  <= '0;
      end else if (advance) begin
         start_phase_ff <= start_phase_in;
         stop_phase_ff  <= stop_phase_in;
         start_stamp_ff <= start_stamp_in;
         stop_stamp_ff  <= stop_stamp_in;
      end
   end

endmodule

// ===== hw/rtl/compressor_start_stop_sequencer.sv =====
// A request accepted into the input register is loaded into the response register
// when the pipeline advances; its response is then held there until it is taken.
// Throughput: one request per cycle while rsp_stall is low; the start/stop decision
// and the phase fall-through are settled combinationally between the two registers.
// Reset (synchronous, active high) clears both sequence phases and time stamps,
// empties the pipeline and loads 30 seconds into both delay registers.
module compressor_start_stop_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  css_pkg::css_req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output css_pkg::css_rsp_type  rsp_data,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  logic [15:0]          csr_write_data
);
   import css_pkg::*;

   logic        in_valid_ff;
   css_req_type in_data_ff;
   logic        out_valid_ff;
   css_rsp_type out_data_ff;
   css_rsp_type step_rsp;
   logic [DELAY_WIDTH-1:0] start_delay_ff;
   logic [DELAY_WIDTH-1:0] stop_delay_ff;
   logic        out_ready;
   logic        advance;
   logic        in_ready;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_stall = !in_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   css_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req         (in_data_ff),
      .start_delay (start_delay_ff),
      .stop_delay  (stop_delay_ff),
      .rsp         (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= DELAY_RESET;
         stop_delay_ff  <= DELAY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_DELAY: start_delay_ff <= csr_write_data;
            CSR_STOP_DELAY:  stop_delay_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
      if (in_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   a_idle_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.command == CMD_NONE) |->
         (rsp_data.pump_start_mask == 3'd0 && rsp_data.pump_stop_mask == 3'd0 &&
          !rsp_data.compressor_start && !rsp_data.compressor_stop &&
          !rsp_data.sequence_result))
      else $error("idle command produced sequence activity");

   a_start_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.command == CMD_START) |->
         (rsp_data.pump_stop_mask == 3'd0 && !rsp_data.compressor_stop))
      else $error("start command produced stop activity");

   a_stop_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.command == CMD_STOP) |->
         (rsp_data.pump_start_mask == 3'd0 && !rsp_data.compressor_start))
      else $error("stop command produced start activity");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled while pipeline could move");

endmodule

// ===== tb/tb_compressor_start_stop_sequencer.sv =====
`timescale 1ns / 1ps

module tb_compressor_start_stop_sequencer;
   import css_pkg::*;

   typedef enum logic [2:0] {
      START_GEO, START_LOOP1, START_LOOP2, START_WAIT, START_COMPRESSOR
   } start_phase_type;

   typedef enum logic [2:0] {
      STOP_COMPRESSOR, STOP_WAIT, STOP_LOOP2, STOP_LOOP1, STOP_GEO
   } stop_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   css_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   css_rsp_type rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = CSR_START_DELAY;
   logic [15:0] csr_write_data = '0;

   css_req_type tick_queue[$];
   css_rsp_type command_queue[$];
   int          ticks_issued = 0;
   int          ticks_accepted = 0;
   int          error_count = 0;
   bit          req_taken = 1'b0;
   bit          quiet = 1'b0;
   int          idle_odds = 11;
   int          send_gap = 0;
   int          stall_left = 0;
   logic [31:0] seconds_counter = '0;

   logic [DELAY_WIDTH-1:0] start_delay = DELAY_RESET;
   logic [DELAY_WIDTH-1:0] stop_delay = DELAY_RESET;
   start_phase_type        start_phase = START_GEO;
   stop_phase_type         stop_phase = STOP_COMPRESSOR;
   logic [31:0]            start_stamp = '0;
   logic [31:0]            stop_stamp = '0;

   compressor_start_stop_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every step that completes, but the last of each sequence, falls through into the next one within the same tick.
   function automatic css_rsp_type sequence_tick(css_req_type r);
      css_rsp_type o;
      logic [31:0] elapsed;
      o = '0;
      if ($signed(r.return_temp) < $signed(r.target_temp)
          && r.sensor_normal_mask == SENSOR_ALL && r.flow_normal) begin
         o.command = r.compressor_on ? CMD_NONE : CMD_START;
      end else begin
         o.command = r.compressor_on ? CMD_STOP : CMD_NONE;
      end
      if (o.command == CMD_START) begin
         if (start_phase == START_GEO) begin
            o.pump_start_mask |= PUMP_GEO;
            o.sequence_result = r.geo_pump_ready;
            if (r.geo_pump_ready) start_phase = START_LOOP1;
         end
         if (start_phase == START_LOOP1) begin
            o.pump_start_mask |= PUMP_LOOP1;
            o.sequence_result = r.loop1_pump_ready;
            if (r.loop1_pump_ready) start_phase = START_LOOP2;
         end
         if (start_phase == START_LOOP2) begin
            o.pump_start_mask |= PUMP_LOOP2;
            o.sequence_result = r.loop2_pump_ready;
            if (r.loop2_pump_ready) begin
               start_stamp = r.seconds_now;
               start_phase = START_WAIT;
            end
         end
         if (start_phase == START_WAIT) begin
            elapsed = r.seconds_now - start_stamp;
            if (elapsed >= {16'd0, start_delay}) start_phase = START_COMPRESSOR;
         end
         if (start_phase == START_COMPRESSOR) begin
            o.compressor_start = 1'b1;
            o.sequence_result = 1'b1;
            start_phase = START_GEO;
         end
      end else if (o.command == CMD_STOP) begin
         if (stop_phase == STOP_COMPRESSOR) begin
            o.compressor_stop = 1'b1;
            o.sequence_result = 1'b1;
            stop_phase = STOP_WAIT;
            stop_stamp = r.seconds_now;
         end
         if (stop_phase == STOP_WAIT) begin
            elapsed = r.seconds_now - stop_stamp;
            if (elapsed >= {16'd0, stop_delay}) stop_phase = STOP_LOOP2;
         end
         if (stop_phase == STOP_LOOP2) begin
            o.pump_stop_mask |= PUMP_LOOP2;
            o.sequence_result = r.loop2_pump_ready;
            if (r.loop2_pump_ready) stop_phase = STOP_LOOP1;
         end
         if (stop_phase == STOP_LOOP1) begin
            o.pump_stop_mask |= PUMP_LOOP1;
            o.sequence_result = r.loop1_pump_ready;
            if (r.loop1_pump_ready) stop_phase = STOP_GEO;
         end
         if (stop_phase == STOP_GEO) begin
            o.pump_stop_mask |= PUMP_GEO;
            o.sequence_result = r.geo_pump_ready;
            stop_phase = STOP_COMPRESSOR;
         end
      end
      return o;
   endfunction

   function automatic css_req_type make_tick(logic [8:0] mask, logic flow, int ret, int tgt,
         logic comp_on, logic geo, logic loop1, logic loop2, logic [31:0] secs);
      css_req_type t;
      t.sensor_normal_mask = mask;
      t.flow_normal = flow;
      t.return_temp = ret[15:0];
      t.target_temp = tgt[15:0];
      t.compressor_on = comp_on;
      t.geo_pump_ready = geo;
      t.loop1_pump_ready = loop1;
      t.loop2_pump_ready = loop2;
      t.seconds_now = secs;
      return t;
   endfunction

   // The start condition fails on exactly one chosen factor when cond_ok is low.
   function automatic css_req_type random_tick(logic cond_ok, logic comp_on);
      css_req_type t;
      int ret;
      int tgt;
      int way;
      if ($urandom_range(0, 49) == 0) seconds_counter = $urandom;
      else if ($urandom_range(0, 19) == 0) seconds_counter += $urandom_range(0, 70000);
      else seconds_counter += $urandom_range(0, 3);
      way = cond_ok ? 0 : $urandom_range(1, 3);
      if (way == 1) begin
         tgt = int'($urandom_range(0, 65535)) - 32768;
         ret = tgt + int'($urandom_range(0, 32767 - tgt));
      end else begin
         ret = int'($urandom_range(0, 65534)) - 32768;
         tgt = ret + 1 + int'($urandom_range(0, 32766 - ret));
      end
      t = make_tick(SENSOR_ALL, 1'b1, ret, tgt, comp_on, $urandom_range(0, 2) != 0,
                    $urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0, seconds_counter);
      if (way == 2) t.sensor_normal_mask = 9'($urandom_range(0, 510));
      if (way == 3) t.flow_normal = 1'b0;
      return t;
   endfunction

   task automatic add_tick(css_req_type t);
      tick_queue.push_back(t);
      ticks_issued++;
   endtask

   task automatic queue_episode();
      int pick;
      int length;
      logic hold;
      css_req_type noise;
      pick = $urandom_range(0, 9);
      length = $urandom_range(1, 12);
      repeat (length) begin
         hold = 1'($urandom_range(0, 1));
         if (pick < 4) begin
            add_tick(random_tick(1'b1, 1'b0));
         end else if (pick < 8) begin
            add_tick(random_tick(1'b0, 1'b1));
         end else if (pick == 8) begin
            add_tick(random_tick(hold, hold));
         end else begin
            noise.sensor_normal_mask = 9'($urandom);
            noise.flow_normal = 1'($urandom);
            noise.return_temp = 16'($urandom);
            noise.target_temp = 16'($urandom);
            noise.compressor_on = 1'($urandom);
            noise.geo_pump_ready = 1'($urandom);
            noise.loop1_pump_ready = 1'($urandom);
            noise.loop2_pump_ready = 1'($urandom);
            noise.seconds_now = $urandom;
            add_tick(noise);
         end
      end
   endtask

   task automatic write_delay(logic [0:0] index, logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      if (index == CSR_START_DELAY) start_delay = value;
      else stop_delay = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_for_responses();
      while (ticks_accepted != ticks_issued || command_queue.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0 && !quiet) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, idle_odds) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0 && !quiet) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, idle_odds) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      css_rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (command_queue.size() == 0) begin
               $error("response with no request waiting for it");
               error_count++;
            end else begin
               want = command_queue.pop_front();
               check_field("command", 3'(want.command), 3'(rsp_data.command));
               check_field("pump_start_mask", want.pump_start_mask, rsp_data.pump_start_mask);
               check_field("pump_stop_mask", want.pump_stop_mask, rsp_data.pump_stop_mask);
               check_field("compressor_start", 3'(want.compressor_start),
                           3'(rsp_data.compressor_start));
               check_field("compressor_stop", 3'(want.compressor_stop),
                           3'(rsp_data.compressor_stop));
               check_field("sequence_result", 3'(want.sequence_result),
                           3'(rsp_data.sequence_result));
            end
         end
         if (req_valid && !req_stall) begin
            command_queue.push_back(sequence_tick(req_data));
            ticks_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] start_setting;
      logic [15:0] stop_setting;
      int phase_base;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the delays at their reset value of 30 seconds.
      add_tick(make_tick(SENSOR_ALL, 1'b1, 0, 0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0));
      add_tick(make_tick(SENSOR_ALL, 1'b1, -5, 5, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
      add_tick(make_tick(SENSOR_ALL, 1'b1, -32768, 32767, 1'b0, 1'b0, 1'b1, 1'b1, 32'd1));
      add_tick(make_tick(SENSOR_ALL, 1'b1, 100, 101, 1'b0, 1'b1, 1'b1, 1'b0, 32'd2));
      add_tick(make_tick(SENSOR_ALL, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFF0));
      add_tick(make_tick(SENSOR_ALL, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_000D));
      add_tick(make_tick(SENSOR_ALL, 1'b1, -1, 0, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_000E));
      add_tick(make_tick(SENSOR_ALL, 1'b1, 32767, -32768, 1'b1, 1'b0, 1'b0, 1'b0, 32'd100));
      add_tick(make_tick(9'h0FF, 1'b1, 0, 1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd129));
      add_tick(make_tick(SENSOR_ALL, 1'b0, 0, 1, 1'b1, 1'b0, 1'b1, 1'b1, 32'd130));
      add_tick(make_tick(SENSOR_ALL, 1'b1, 0, 1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd131));
      add_tick(make_tick(SENSOR_ALL, 1'b1, 7, 7, 1'b1, 1'b0, 1'b0, 1'b0, 32'd200));
      wait_for_responses();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               start_setting = 16'd0;
               stop_setting = 16'd0;
               idle_odds = 3;
            end
            1: begin
               start_setting = 16'hFFFF;
               stop_setting = 16'hFFFF;
               idle_odds = 11;
            end
            2: begin
               start_setting = 16'($urandom_range(1, 8));
               stop_setting = 16'($urandom_range(1, 8));
               idle_odds = 40;
            end
            3: begin
               start_setting = 16'd0;
               stop_setting = 16'hFFFF;
               idle_odds = 7;
            end
            default: begin
               start_setting = 16'($urandom_range(0, 20));
               stop_setting = 16'($urandom_range(0, 20));
            end
         endcase
         write_delay(CSR_START_DELAY, start_setting);
         write_delay(CSR_STOP_DELAY, stop_setting);
         quiet = (p == 4);
         if (p == 0) begin
            add_tick(make_tick(SENSOR_ALL, 1'b1, 0, 1, 1'b0, 1'b1, 1'b1, 1'b1, 32'd300));
            add_tick(make_tick(SENSOR_ALL, 1'b1, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 32'd301));
            add_tick(make_tick(SENSOR_ALL, 1'b1, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 32'd302));
            add_tick(make_tick(SENSOR_ALL, 1'b1, -32768, -32768, 1'b0, 1'b1, 1'b1, 1'b1,
                               32'd303));
         end
         phase_base = ticks_issued;
         while (ticks_issued - phase_base < 200) queue_episode();
         wait_for_responses();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== compressor_start_stop_sequencer.f =====
hw/rtl/css_pkg.sv
hw/rtl/css_step.sv
hw/rtl/compressor_start_stop_sequencer.sv
tb/tb_compressor_start_stop_sequencer.sv
